@@ design/sct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and codes for the shell command tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int POS_WIDTH_DEF = 16;
    localparam int TOKEN_POS_W   = 16;
    localparam int MAX_RES       = 3;
    localparam int CNT_W         = $clog2(MAX_RES + 1);

    // result kinds
    localparam logic [2:0] KIND_CHAR = 3'd0;
    localparam logic [2:0] KIND_WEND = 3'd1;
    localparam logic [2:0] KIND_OP   = 3'd2;
    localparam logic [2:0] KIND_END  = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;

    // operator codes
    localparam logic [3:0] OP_OR         = 4'd0;
    localparam logic [3:0] OP_AND        = 4'd1;
    localparam logic [3:0] OP_ERR_APPEND = 4'd2;
    localparam logic [3:0] OP_ERR        = 4'd3;
    localparam logic [3:0] OP_APPEND     = 4'd4;
    localparam logic [3:0] OP_PIPE       = 4'd5;
    localparam logic [3:0] OP_AMP        = 4'd6;
    localparam logic [3:0] OP_SEMI       = 4'd7;
    localparam logic [3:0] OP_IN         = 4'd8;
    localparam logic [3:0] OP_OUT        = 4'd9;

    typedef enum logic [3:0] {
        MODE_START   = 4'd0,
        MODE_SAW1    = 4'd1,
        MODE_SAW1GT  = 4'd2,
        MODE_SAW2    = 4'd3,
        MODE_SAW2GT  = 4'd4,
        MODE_GT      = 4'd5,
        MODE_PIPE    = 4'd6,
        MODE_AMP     = 4'd7,
        MODE_WORD    = 4'd8,
        MODE_COMMENT = 4'd9
    } sct_mode_t;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } sct_quote_t;

    typedef struct packed {
        sct_mode_t  mode;
        sct_quote_t quote;
        logic       esc;
        logic       quoted;
    } sct_lex_state_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_line;
    } sct_in_t;

    typedef struct packed {
        logic [2:0]             kind;
        logic [7:0]             char_out;
        logic [3:0]             op_code;
        logic                   was_quoted;
        logic [TOKEN_POS_W-1:0] token_pos;
        logic                   last;
    } sct_out_t;

endpackage

@@ design/sct_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_lexer
// One character step of the tokenizer: next lexer state and up to three
// result items.
// ----------------------------------------------------------------------------
module sct_lexer
    import sct_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  sct_lex_state_t               st,
    input  logic [POS_WIDTH-1:0]         char_index,
    input  logic [POS_WIDTH-1:0]         token_start,
    input  sct_in_t                      item,
    output sct_lex_state_t               st_next,
    output logic [POS_WIDTH-1:0]         char_index_next,
    output logic [POS_WIDTH-1:0]         token_start_next,
    output sct_out_t [MAX_RES-1:0]       res,
    output logic [CNT_W-1:0]             res_cnt
);

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_TWO  = 8'h32;
    localparam logic [7:0] CH_BAR  = 8'h7c;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_GT   = 8'h3e;
    localparam logic [7:0] CH_LT   = 8'h3c;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_BSL  = 8'h5c;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_NL   = 8'h0a;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic is_break(input logic [7:0] c);
        return (c == CH_BAR) || (c == CH_AMP) || (c == CH_SEMI) || (c == CH_LT) || (c == CH_GT);
    endfunction

    function automatic sct_out_t make_res(input logic [2:0] kind, input logic [7:0] ch,
                                          input logic [3:0] op, input logic q,
                                          input logic [TOKEN_POS_W-1:0] pos);
        sct_out_t r;
        r.kind       = kind;
        r.char_out   = ch;
        r.op_code    = op;
        r.was_quoted = q;
        r.token_pos  = pos;
        r.last       = 1'b0;
        return r;
    endfunction

    logic [7:0]             c;
    logic [TOKEN_POS_W-1:0] idx16;
    logic [TOKEN_POS_W-1:0] ts16;

    assign c     = item.char_in;
    assign idx16 = TOKEN_POS_W'(char_index);
    assign ts16  = TOKEN_POS_W'(token_start);

    // token start handling for a character arriving outside any token
    logic           sc_emit;
    logic           sc_set_ts;
    sct_out_t       sc_res;
    sct_lex_state_t sc_st;

    always_comb
    begin
        sc_emit     = 1'b0;
        sc_set_ts   = 1'b0;
        sc_res      = make_res(KIND_CHAR, c, 4'd0, 1'b0, idx16);
        sc_st.mode  = MODE_START;
        sc_st.quote = Q_NONE;
        sc_st.esc   = 1'b0;
        sc_st.quoted = st.quoted;
        if (!is_space(c))
        begin
            sc_set_ts = 1'b1;
            priority if (c == CH_HASH)
                sc_st.mode = MODE_COMMENT;
            else if (c == CH_ONE)
                sc_st.mode = MODE_SAW1;
            else if (c == CH_TWO)
                sc_st.mode = MODE_SAW2;
            else if (c == CH_BAR)
                sc_st.mode = MODE_PIPE;
            else if (c == CH_AMP)
                sc_st.mode = MODE_AMP;
            else if (c == CH_GT)
                sc_st.mode = MODE_GT;
            else if (c == CH_SEMI)
            begin
                sc_emit = 1'b1;
                sc_res  = make_res(KIND_OP, 8'd0, OP_SEMI, 1'b0, idx16);
            end
            else if (c == CH_LT)
            begin
                sc_emit = 1'b1;
                sc_res  = make_res(KIND_OP, 8'd0, OP_IN, 1'b0, idx16);
            end
            else
            begin
                // open a fresh word with this character
                sc_st.mode   = MODE_WORD;
                sc_st.quoted = 1'b0;
                priority if (c == CH_BSL)
                    sc_st.esc = 1'b1;
                else if (c == CH_SQ)
                begin
                    sc_st.quoted = 1'b1;
                    sc_st.quote  = Q_SINGLE;
                end
                else if (c == CH_DQ)
                begin
                    sc_st.quoted = 1'b1;
                    sc_st.quote  = Q_DOUBLE;
                end
                else
                    sc_emit = 1'b1;
            end
        end
    end

    logic                   run_word;
    logic                   run_start;
    logic                   digit_word;
    logic                   is_err;
    sct_quote_t             wq;
    logic                   we;
    logic                   wqd;
    logic [TOKEN_POS_W-1:0] stop;
    logic [CNT_W-1:0]       n;
    sct_out_t [MAX_RES-1:0] list;
    sct_lex_state_t         nst;
    logic [POS_WIDTH-1:0]   nts;
    logic [POS_WIDTH-1:0]   nidx;

    always_comb
    begin
        n          = '0;
        list       = '0;
        nst        = st;
        nts        = token_start;
        nidx       = (char_index == '1) ? char_index : char_index + POS_WIDTH'(1);
        run_word   = 1'b0;
        run_start  = 1'b0;
        digit_word = 1'b0;
        is_err     = 1'b0;
        stop       = idx16;
        wq         = st.quote;
        we         = st.esc;
        wqd        = st.quoted;
        if (item.end_line)
        begin
            // flush the pending token, then close the line
            unique case (st.mode)
                MODE_SAW1, MODE_SAW2:
                begin
                    list[n] = make_res(KIND_CHAR, (st.mode == MODE_SAW1) ? CH_ONE : CH_TWO,
                                       4'd0, 1'b0, ts16);
                    n = n + 1'b1;
                    list[n] = make_res(KIND_WEND, 8'd0, 4'd0, 1'b0, ts16);
                    n = n + 1'b1;
                end
                MODE_SAW1GT, MODE_GT:
                begin
                    list[n] = make_res(KIND_OP, 8'd0, OP_OUT, 1'b0, ts16);
                    n = n + 1'b1;
                end
                MODE_SAW2GT:
                begin
                    list[n] = make_res(KIND_OP, 8'd0, OP_ERR, 1'b0, ts16);
                    n = n + 1'b1;
                end
                MODE_PIPE:
                begin
                    list[n] = make_res(KIND_OP, 8'd0, OP_PIPE, 1'b0, ts16);
                    n = n + 1'b1;
                end
                MODE_AMP:
                begin
                    list[n] = make_res(KIND_OP, 8'd0, OP_AMP, 1'b0, ts16);
                    n = n + 1'b1;
                end
                MODE_WORD:
                begin
                    // trailing backslash stays a literal
                    if (st.esc)
                    begin
                        list[n] = make_res(KIND_CHAR, CH_BSL, 4'd0, 1'b0, ts16);
                        n = n + 1'b1;
                    end
                    if (st.quote != Q_NONE)
                    begin
                        list[n] = make_res(KIND_ERR, 8'd0, 4'd0, 1'b0, ts16);
                        n = n + 1'b1;
                        is_err = 1'b1;
                    end
                    else
                    begin
                        list[n] = make_res(KIND_WEND, 8'd0, 4'd0, st.quoted, ts16);
                        n = n + 1'b1;
                    end
                end
                MODE_COMMENT:
                    stop = ts16;
                default:
                begin
                end
            endcase
            if (!is_err)
            begin
                list[n] = make_res(KIND_END, 8'd0, 4'd0, 1'b0, stop);
                n = n + 1'b1;
            end
            nst.mode   = MODE_START;
            nst.quote  = Q_NONE;
            nst.esc    = 1'b0;
            nst.quoted = 1'b0;
            nts        = '0;
            nidx       = '0;
        end
        else
        begin
            unique case (st.mode)
                MODE_COMMENT:
                begin
                end
                MODE_SAW1, MODE_SAW2:
                begin
                    if (c == CH_GT)
                        nst.mode = (st.mode == MODE_SAW1) ? MODE_SAW1GT : MODE_SAW2GT;
                    else
                    begin
                        // digit turns out to start a word
                        list[n] = make_res(KIND_CHAR, (st.mode == MODE_SAW1) ? CH_ONE : CH_TWO,
                                           4'd0, 1'b0, ts16);
                        n = n + 1'b1;
                        digit_word = 1'b1;
                        run_word   = 1'b1;
                    end
                end
                MODE_SAW1GT, MODE_GT:
                begin
                    nst.mode = MODE_START;
                    list[n] = make_res(KIND_OP, 8'd0, (c == CH_GT) ? OP_APPEND : OP_OUT,
                                       1'b0, ts16);
                    n = n + 1'b1;
                    run_start = (c != CH_GT);
                end
                MODE_SAW2GT:
                begin
                    nst.mode = MODE_START;
                    list[n] = make_res(KIND_OP, 8'd0, (c == CH_GT) ? OP_ERR_APPEND : OP_ERR,
                                       1'b0, ts16);
                    n = n + 1'b1;
                    run_start = (c != CH_GT);
                end
                MODE_PIPE:
                begin
                    nst.mode = MODE_START;
                    list[n] = make_res(KIND_OP, 8'd0, (c == CH_BAR) ? OP_OR : OP_PIPE,
                                       1'b0, ts16);
                    n = n + 1'b1;
                    run_start = (c != CH_BAR);
                end
                MODE_AMP:
                begin
                    nst.mode = MODE_START;
                    list[n] = make_res(KIND_OP, 8'd0, (c == CH_AMP) ? OP_AND : OP_AMP,
                                       1'b0, ts16);
                    n = n + 1'b1;
                    run_start = (c != CH_AMP);
                end
                MODE_WORD:
                    run_word = 1'b1;
                default:
                    run_start = 1'b1;
            endcase

            if (run_word)
            begin
                wq         = digit_word ? Q_NONE : st.quote;
                we         = digit_word ? 1'b0 : st.esc;
                wqd        = digit_word ? 1'b0 : st.quoted;
                nst.mode   = MODE_WORD;
                nst.quote  = wq;
                nst.esc    = 1'b0;
                nst.quoted = wqd;
                priority if (we)
                begin
                    // escaped newline is dropped
                    if (c != CH_NL)
                    begin
                        list[n] = make_res(KIND_CHAR, c, 4'd0, 1'b0, ts16);
                        n = n + 1'b1;
                    end
                end
                else if (wq == Q_NONE && (is_space(c) || is_break(c)))
                begin
                    list[n] = make_res(KIND_WEND, 8'd0, 4'd0, wqd, ts16);
                    n = n + 1'b1;
                    run_start = 1'b1;
                end
                else if (c == CH_BSL && wq != Q_SINGLE)
                    nst.esc = 1'b1;
                else if (c == CH_SQ && wq != Q_DOUBLE)
                begin
                    nst.quoted = 1'b1;
                    nst.quote  = (wq == Q_SINGLE) ? Q_NONE : Q_SINGLE;
                end
                else if (c == CH_DQ && wq != Q_SINGLE)
                begin
                    nst.quoted = 1'b1;
                    nst.quote  = (wq == Q_DOUBLE) ? Q_NONE : Q_DOUBLE;
                end
                else
                begin
                    list[n] = make_res(KIND_CHAR, c, 4'd0, 1'b0, ts16);
                    n = n + 1'b1;
                end
            end

            if (run_start)
            begin
                nst = sc_st;
                if (sc_set_ts)
                    nts = char_index;
                if (sc_emit)
                begin
                    list[n] = sc_res;
                    n = n + 1'b1;
                end
            end
        end
        if (n != '0)
            list[n - 1'b1].last = 1'b1;
    end

    assign st_next          = nst;
    assign token_start_next = nts;
    assign char_index_next  = nidx;
    assign res              = list;
    assign res_cnt          = n;

endmodule

@@ design/shell_command_tokenizer.sv @@
`timescale 1ns / 1ps
// An accepted request waits in the input register until the result buffer
// is empty or emptying. Throughput: one character per cycle while each
// yields at most one result and tok_ready is high; one with more results
// holds the three-entry buffer until the output port has sent them all,
// one per cycle. Reset: rst_n asynchronously empties both stages and
// returns the lexer to token start with zero positions; no clearing pass.
// ----------------------------------------------------------------------------
// shell_command_tokenizer
// Streaming tokenizer for shell command lines: words, quotes, escapes,
// operators, comments and end-of-line handling.
// ----------------------------------------------------------------------------
module shell_command_tokenizer
    import sct_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     char_valid,
    output logic     char_ready,
    input  sct_in_t  char_item,
    output logic     tok_valid,
    input  logic     tok_ready,
    output sct_out_t tok_item
);

    sct_in_t                in_reg;
    logic                   in_valid_reg;
    sct_lex_state_t         st_reg;
    sct_lex_state_t         st_next;
    logic [POS_WIDTH-1:0]   char_index_reg;
    logic [POS_WIDTH-1:0]   char_index_next;
    logic [POS_WIDTH-1:0]   token_start_reg;
    logic [POS_WIDTH-1:0]   token_start_next;
    sct_out_t [MAX_RES-1:0] res_reg;
    sct_out_t [MAX_RES-1:0] res_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic                   tok_take;
    logic                   load;

    sct_lexer #(
        .POS_WIDTH (POS_WIDTH)
    ) u_lexer (
        .st               (st_reg),
        .char_index       (char_index_reg),
        .token_start      (token_start_reg),
        .item             (in_reg),
        .st_next          (st_next),
        .char_index_next  (char_index_next),
        .token_start_next (token_start_next),
        .res              (res_next),
        .res_cnt          (cnt_next)
    );

    assign tok_valid  = (cnt_reg != '0);
    assign tok_item   = res_reg[0];
    assign tok_take   = tok_valid && tok_ready;
    // lex the held request once the result buffer is empty or emptying now
    assign load       = in_valid_reg &&
                        ((cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && tok_ready));
    assign char_ready = !in_valid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            cnt_reg         <= '0;
            st_reg.mode     <= MODE_START;
            st_reg.quote    <= Q_NONE;
            st_reg.esc      <= 1'b0;
            st_reg.quoted   <= 1'b0;
            char_index_reg  <= '0;
            token_start_reg <= '0;
        end
        else
        begin
            if (char_ready)
                in_valid_reg <= char_valid;
            if (load)
            begin
                cnt_reg         <= cnt_next;
                st_reg          <= st_next;
                char_index_reg  <= char_index_next;
                token_start_reg <= token_start_next;
            end
            else if (tok_take)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_ready && char_valid)
            in_reg <= char_item;
        if (load)
            res_reg <= res_next;
        else if (tok_take)
        begin
            // advance the queue toward the output slot
            for (int i = 0; i < MAX_RES - 1; i++)
                res_reg[i] <= res_reg[i + 1];
        end
    end

`ifndef SYNTH
    a_last_on_tail: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> res_reg[cnt_reg - 1'b1].last)
        else $error("final result of a request lacks its last flag");

    a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg > CNT_W'(1)) |-> !res_reg[0].last)
        else $error("last flag shown while results of the request remain");

    a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (load && in_reg.end_line) |=>
            (st_reg.mode == MODE_START && char_index_reg == '0 && token_start_reg == '0))
        else $error("lexer state not cleared after end of line");
`endif

endmodule

@@ tb/sct_token_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_token_checker
// Watches both channels of the shell command tokenizer. Runs its own lexer
// on every accepted character request, queues the tokens it should produce
// and compares each accepted token with the oldest one queued.
// ----------------------------------------------------------------------------
module sct_token_checker
    import sct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_ready,
    input  sct_in_t     char_item,
    input  logic        tok_valid,
    input  logic        tok_ready,
    input  sct_out_t    tok_item,
    output int unsigned fail_count,
    output int unsigned pending_count
);

    localparam int POS_W = POS_WIDTH_DEF;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_PIPE   = 8'h7C;

    sct_mode_t        mode;
    sct_quote_t       quote;
    logic             esc;
    logic             quoted;
    logic [POS_W-1:0] cidx;
    logic [POS_W-1:0] tstart;
    sct_out_t         expected_tokens[$];

    task automatic push_token(input logic [2:0] kind, input logic [7:0] ch,
                              input logic [3:0] op, input logic q,
                              input logic [POS_W-1:0] pos);
        sct_out_t t;
        t.kind       = kind;
        t.char_out   = ch;
        t.op_code    = op;
        t.was_quoted = q;
        t.token_pos  = pos[TOKEN_POS_W-1:0];
        t.last       = 1'b0;
        expected_tokens.push_back(t);
    endtask

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_break(input logic [7:0] c);
        return c == CH_PIPE || c == CH_AMP || c == CH_SEMI || c == CH_LT || c == CH_GT;
    endfunction

    // token start on a blank or an operator character
    task automatic open_op(input logic [7:0] c, input logic [POS_W-1:0] idx);
        if (is_blank(c))
            return;
        tstart = idx;
        case (c)
            CH_PIPE: mode = MODE_PIPE;
            CH_AMP:  mode = MODE_AMP;
            CH_GT:   mode = MODE_GT;
            CH_SEMI: push_token(KIND_OP, '0, OP_SEMI, 1'b0, idx);
            CH_LT:   push_token(KIND_OP, '0, OP_IN, 1'b0, idx);
            default: ;
        endcase
    endtask

    task automatic open_word();
        mode   = MODE_WORD;
        quote  = Q_NONE;
        esc    = 1'b0;
        quoted = 1'b0;
    endtask

    task automatic word_char(input logic [7:0] c, input logic [POS_W-1:0] idx);
        if (esc)
        begin
            esc = 1'b0;
            // escaped newline is a line continuation: drop it
            if (c != CH_NL)
                push_token(KIND_CHAR, c, '0, 1'b0, tstart);
        end
        else if (quote == Q_NONE && (is_blank(c) || is_break(c)))
        begin
            push_token(KIND_WEND, '0, '0, quoted, tstart);
            mode = MODE_START;
            open_op(c, idx);
        end
        else if (c == CH_BSLASH && quote != Q_SINGLE)
            esc = 1'b1;
        else if (c == CH_SQUOTE && quote != Q_DOUBLE)
        begin
            quoted = 1'b1;
            if (quote == Q_SINGLE)
                quote = Q_NONE;
            else
                quote = Q_SINGLE;
        end
        else if (c == CH_DQUOTE && quote != Q_SINGLE)
        begin
            quoted = 1'b1;
            if (quote == Q_DOUBLE)
                quote = Q_NONE;
            else
                quote = Q_DOUBLE;
        end
        else
            push_token(KIND_CHAR, c, '0, 1'b0, tstart);
    endtask

    task automatic start_char(input logic [7:0] c, input logic [POS_W-1:0] idx);
        if (is_blank(c))
            return;
        if (is_break(c))
        begin
            open_op(c, idx);
            return;
        end
        tstart = idx;
        if (c == CH_HASH)
            mode = MODE_COMMENT;
        else if (c == CH_ONE)
            mode = MODE_SAW1;
        else if (c == CH_TWO)
            mode = MODE_SAW2;
        else
        begin
            open_word();
            word_char(c, idx);
        end
    endtask

    // a held digit turned out to be the head of a word
    task automatic digit_word(input logic [7:0] digit, input logic [7:0] c,
                              input logic [POS_W-1:0] idx);
        open_word();
        push_token(KIND_CHAR, digit, '0, 1'b0, tstart);
        word_char(c, idx);
    endtask

    task automatic pending_op(input logic [7:0] c, input logic [7:0] second,
                              input logic [3:0] op2, input logic [3:0] op1,
                              input logic [POS_W-1:0] idx);
        mode = MODE_START;
        if (c == second)
            push_token(KIND_OP, '0, op2, 1'b0, tstart);
        else
        begin
            push_token(KIND_OP, '0, op1, 1'b0, tstart);
            start_char(c, idx);
        end
    endtask

    task automatic clear_line();
        mode   = MODE_START;
        quote  = Q_NONE;
        esc    = 1'b0;
        quoted = 1'b0;
        cidx   = '0;
        tstart = '0;
    endtask

    task automatic finish_line();
        logic [POS_W-1:0] stop;
        bit               open_quote;
        stop       = cidx;
        open_quote = 1'b0;
        case (mode)
            MODE_SAW1, MODE_SAW2:
            begin
                push_token(KIND_CHAR, (mode == MODE_SAW1) ? CH_ONE : CH_TWO, '0, 1'b0, tstart);
                push_token(KIND_WEND, '0, '0, 1'b0, tstart);
            end
            MODE_SAW1GT, MODE_GT: push_token(KIND_OP, '0, OP_OUT, 1'b0, tstart);
            MODE_SAW2GT:          push_token(KIND_OP, '0, OP_ERR, 1'b0, tstart);
            MODE_PIPE:            push_token(KIND_OP, '0, OP_PIPE, 1'b0, tstart);
            MODE_AMP:             push_token(KIND_OP, '0, OP_AMP, 1'b0, tstart);
            MODE_WORD:
            begin
                // trailing backslash stays a literal character
                if (esc)
                    push_token(KIND_CHAR, CH_BSLASH, '0, 1'b0, tstart);
                if (quote != Q_NONE)
                begin
                    open_quote = 1'b1;
                    push_token(KIND_ERR, '0, '0, 1'b0, tstart);
                end
                else
                    push_token(KIND_WEND, '0, '0, quoted, tstart);
            end
            MODE_COMMENT: stop = tstart;
            default: ;
        endcase
        if (!open_quote)
            push_token(KIND_END, '0, '0, 1'b0, stop);
        clear_line();
    endtask

    task automatic predict_tokens(input sct_in_t req);
        int unsigned      base;
        logic [POS_W-1:0] idx;
        logic [7:0]       c;
        sct_out_t         t;
        base = expected_tokens.size();
        idx  = cidx;
        c    = req.char_in;
        if (req.end_line)
            finish_line();
        else
        begin
            case (mode)
                MODE_COMMENT: ;
                MODE_SAW1:
                    if (c == CH_GT)
                        mode = MODE_SAW1GT;
                    else
                        digit_word(CH_ONE, c, idx);
                MODE_SAW2:
                    if (c == CH_GT)
                        mode = MODE_SAW2GT;
                    else
                        digit_word(CH_TWO, c, idx);
                MODE_SAW1GT, MODE_GT: pending_op(c, CH_GT, OP_APPEND, OP_OUT, idx);
                MODE_SAW2GT:          pending_op(c, CH_GT, OP_ERR_APPEND, OP_ERR, idx);
                MODE_PIPE:            pending_op(c, CH_PIPE, OP_OR, OP_PIPE, idx);
                MODE_AMP:             pending_op(c, CH_AMP, OP_AND, OP_AMP, idx);
                MODE_WORD:            word_char(c, idx);
                default:
                begin
                    mode = MODE_START;
                    start_char(c, idx);
                end
            endcase
            // position saturates on long lines
            if (cidx != '1)
                cidx = cidx + 1'b1;
        end
        if (expected_tokens.size() > base)
        begin
            t      = expected_tokens.pop_back();
            t.last = 1'b1;
            expected_tokens.push_back(t);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_token(input sct_out_t got);
        sct_out_t want;
        if (expected_tokens.size() == 0)
        begin
            fail_count++;
            $display("%0t: token with none expected: kind %0d char %0d op %0d quoted %0d pos %0d",
                     $time, got.kind, got.char_out, got.op_code, got.was_quoted, got.token_pos);
        end
        else
        begin
            want = expected_tokens.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("char_out", want.char_out, got.char_out);
            check_field("op_code", want.op_code, got.op_code);
            check_field("was_quoted", want.was_quoted, got.was_quoted);
            check_field("token_pos", want.token_pos, got.token_pos);
            check_field("last", want.last, got.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line();
            expected_tokens.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            // compare first so a token can never match a request from this same edge
            if (tok_valid && tok_ready)
                check_token(tok_item);
            if (char_valid && char_ready)
                predict_tokens(char_item);
            pending_count = expected_tokens.size();
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the shell command tokenizer bench: clock and reset, character
// requests from directed and random command lines with random gaps, a token
// sink with random back-pressure, a watchdog and the final verdict.
// ----------------------------------------------------------------------------
module tb;
    import sct_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_ITEMS   = 210;

    logic     clk        = 1'b0;
    logic     rst_n      = 1'b0;
    logic     char_valid = 1'b0;
    logic     char_ready;
    sct_in_t  char_item  = '0;
    logic     tok_valid;
    logic     tok_ready  = 1'b0;
    sct_out_t tok_item;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned idle_cycles = 0;
    int unsigned random_sent = 0;
    bit          tx_noisy    = 1'b0;
    bit          hold_req    = 1'b0;
    logic [7:0]  line_buf[$];

    string op_texts[12] = '{"||", "&&", "2>>", "2>", ">>", "|", "&", ";", "<", ">",
                            "1>", "1>>"};
    string word_pool    = "abz019#._-=";
    string quoted_pool  = "a b|;\\$>#'";

    always #1 clk = ~clk;

    shell_command_tokenizer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_item   (tok_item)
    );

    sct_token_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_ready    (char_ready),
        .char_item     (char_item),
        .tok_valid     (tok_valid),
        .tok_ready     (tok_ready),
        .tok_item      (tok_item),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic offer_request(input logic [7:0] c, input logic eol);
        sct_in_t req;
        int      gap;
        req.char_in  = c;
        req.end_line = eol;
        char_item  <= req;
        char_valid <= 1'b1;
        do
            @(posedge clk);
        while (!char_ready);
        gap = tx_noisy ? pick_gap() : 0;
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic add_word();
        int    n;
        int    k;
        int    r;
        string q;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                q = ($urandom_range(0, 1) != 0) ? "'" : "\"";
                add_text(q);
                k = $urandom_range(0, 4);
                for (int j = 0; j < k; j++)
                    line_buf.push_back(quoted_pool[$urandom_range(0, quoted_pool.len() - 1)]);
                add_text(q);
            end
            else if (r == 1)
            begin
                add_text("\\");
                case ($urandom_range(0, 2))
                    0:       add_text("\n");
                    1:       line_buf.push_back(8'($urandom_range(0, 255)));
                    default: line_buf.push_back(word_pool[$urandom_range(0, word_pool.len() - 1)]);
                endcase
            end
            else
                line_buf.push_back(word_pool[$urandom_range(0, word_pool.len() - 1)]);
        end
    endtask

    // the end-of-line request carries a random, ignored character
    task automatic send_line();
        foreach (line_buf[i])
            offer_request(line_buf[i], 1'b0);
        offer_request(8'($urandom_range(0, 255)), 1'b1);
        line_buf.delete();
    endtask

    task automatic wait_drained();
        char_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // token sink: random stalls, quiet stretches, and one long hold-off on request
    initial
    begin : token_sink
        int unsigned tick;
        int          stall;
        bit          noisy;
        tick  = 0;
        stall = 0;
        noisy = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            tick++;
            if (tick % 150 == 0)
                noisy = ($urandom_range(0, 2) != 0);
            if (hold_req)
            begin
                hold_req = 1'b0;
                tok_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall > 0)
            begin
                stall--;
                tok_ready <= 1'b0;
            end
            else if (noisy && $urandom_range(0, 3) == 0)
            begin
                stall = pick_gap();
                tok_ready <= 1'b0;
            end
            else
                tok_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (char_valid && char_ready) || (tok_valid && tok_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        int line_no;
        int ntok;
        int r;
        line_no = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_noisy = 1'b1;

        // every operator; the pending ones flushed by the next character or end of line
        add_text("||&&2>>2>|&;<>");
        send_line();
        add_text(">>1>1>>x");
        send_line();
        // escaped newline, both quote styles, comment at token start
        add_text("a\\\nb'c'\"d\" #z");
        send_line();
        // open quote at end of line, then a trailing backslash
        add_text("'x");
        send_line();
        add_text("x\\");
        send_line();
        // zero and all-ones bytes are plain word characters; lone digit held to the end
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        add_text(" 2");
        send_line();

        while (random_sent < RANDOM_ITEMS)
        begin
            tx_noisy = ($urandom_range(0, 3) != 0);
            if (line_no == 4)
            begin
                // one long word while the sink holds off: fill the block and stall requests
                hold_req = 1'b1;
                repeat (30) add_word();
            end
            else
            begin
                ntok = $urandom_range(1, 6);
                for (int i = 0; i < ntok; i++)
                begin
                    r = $urandom_range(0, 11);
                    if (r < 5)
                        add_word();
                    else if (r < 9)
                        add_text(op_texts[$urandom_range(0, 11)]);
                    else if (r == 9)
                    begin
                        add_text("#");
                        add_word();
                    end
                    else
                        line_buf.push_back(8'($urandom_range(0, 255)));
                    r = $urandom_range(0, 9);
                    if (r < 6)
                        add_text(" ");
                    else if (r == 8)
                        add_text("\t");
                    else if (r == 9)
                        add_text(" \n ");
                end
                // broken endings now and then
                case ($urandom_range(0, 9))
                    0:       add_text("'ab");
                    1:       add_text("\"c");
                    2:       add_text("x\\");
                    default: ;
                endcase
            end
            if (line_no == 9)
                wait_drained();
            random_sent += line_buf.size() + 1;
            send_line();
            line_no++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
